// ===== rtl/core/pipqt_pkg.sv =====
// ----------------------------------------------------------------------------
// pipqt_pkg: shared types and constants
// Request codes, quadrant codes and the result payload.
// ----------------------------------------------------------------------------
package pipqt_pkg;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam int REQ_WIDTH = 2;

   // winding step codes, quadrant difference modulo four
   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_CCW  = 2'd1;
   localparam logic [1:0] STEP_DIAG = 2'd2;
   localparam logic [1:0] STEP_CW   = 2'd3;

   // winding count range needs values -2*MAX..2*MAX; 11 bits covers 256 vertices
   localparam int ALPHA_WIDTH = 11;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

   // quadrant of (x,y) around (px,py)
   function automatic logic [1:0] quadrant(input logic gx, input logic gy);
      logic [1:0] q;
      begin
         q = gy ? (gx ? 2'd2 : 2'd3) : (gx ? 2'd1 : 2'd0);
         return q;
      end
   endfunction

endpackage

// ===== rtl/core/pipqt_if.sv =====
// ----------------------------------------------------------------------------
// pipqt_req_if / pipqt_rsp_if: valid/ready channels
// Request channel carries type and coordinates; response channel the result.
// ----------------------------------------------------------------------------
interface pipqt_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [pipqt_pkg::REQ_WIDTH-1:0] req_type;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;
   modport source (output valid, output req_type, output coord_x, output coord_y,
                   input ready);
   modport sink   (input valid, input req_type, input coord_x, input coord_y,
                   output ready);
endinterface

interface pipqt_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic status;
   modport source (output valid, output inside_res, output status, input ready);
   modport sink   (input valid, input inside_res, input status, output ready);
endinterface

// ===== rtl/core/point_in_polygon_quadrant_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_quadrant_test: quadrant winding test against a vertex ring
// Clear and append answer from idle straight into the response register.
// A query spins the ring through its n stored vertices, then passes the drain
// and result states to load the response register; the ring rotates one cell
// per cycle into a two-stage edge unit, and no new request is taken until idle.
// Synchronous active-high reset empties the table; the cells are not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_quadrant_test #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_WIDTH  = 32
) (
   input logic clock,
   input logic reset,
   pipqt_req_if.sink   req,
   pipqt_rsp_if.source rsp
);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SPIN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;    // rotations done during a query
   logic signed [COORD_WIDTH-1:0] px_ff, py_ff, ox_ff, oy_ff;
   logic          rsp_vld_ff, rsp_vld_in;
   pipqt_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [COORD_WIDTH-1:0] vx [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] vy [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] load_en;
   logic shift_en, start, edge_vld, edge_busy, edge_inside, accept, full;

   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp.ready);
   assign full       = (count_ff == CW'(MAX_VERTICES));
   assign start      = accept && (req.req_type == pipqt_pkg::REQ_QUERY) && (count_ff != '0);
   assign shift_en   = (state_ff == ST_SPIN);
   assign edge_vld   = shift_en;

   // the ring: cell 0 always shows the next vertex; cell count-1 wraps to 0
   genvar g;
   generate
      for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
         logic signed [COORD_WIDTH-1:0] nx, ny;
         assign load_en[g] = accept && (req.req_type == pipqt_pkg::REQ_APPEND) &&
                             !full && (count_ff[IW-1:0] == IW'(g));
         if (g == MAX_VERTICES - 1) begin : g_last
            assign nx = vx[0];
            assign ny = vy[0];
         end else begin : g_mid
            assign nx = (CW'(g + 1) == count_ff) ? vx[0] : vx[g+1];
            assign ny = (CW'(g + 1) == count_ff) ? vy[0] : vy[g+1];
         end
         pipqt_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
            .clock, .load_en(load_en[g]), .shift_en,
            .load_x(req.coord_x), .load_y(req.coord_y),
            .nbr_x(nx), .nbr_y(ny), .vx(vx[g]), .vy(vy[g]));
      end
   endgenerate

   pipqt_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
      .clock, .reset, .start, .edge_vld,
      .px(px_ff), .py(py_ff), .ox(ox_ff), .oy(oy_ff),
      .cx(vx[0]), .cy(vy[0]),
      .busy(edge_busy), .in_poly(edge_inside));

   // hold the point; track the previous vertex as the ring turns
   always_ff @(posedge clock) begin
      if (start) begin
         px_ff <= req.coord_x;
         py_ff <= req.coord_y;
         ox_ff <= vx[count_ff[IW-1:0] - 1'b1];
         oy_ff <= vy[count_ff[IW-1:0] - 1'b1];
      end else if (shift_en) begin
         ox_ff <= vx[0];
         oy_ff <= vy[0];
      end
   end

   // sequence requests and results
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               case (req.req_type)
                  pipqt_pkg::REQ_CLEAR: begin
                     count_in   = '0;
                     rsp_vld_in = 1'b1;
                  end
                  pipqt_pkg::REQ_APPEND: begin
                     if (full) rsp_in.status = 1'b1;
                     else count_in = count_ff + 1'b1;
                     rsp_vld_in = 1'b1;
                  end
                  pipqt_pkg::REQ_QUERY: begin
                     if (count_ff == '0) rsp_vld_in = 1'b1;
                     else begin
                        state_in = ST_SPIN;
                        step_in  = '0;
                     end
                  end
                  default: rsp_vld_in = 1'b1;
               endcase
            end
         end
         ST_SPIN: begin
            step_in = step_ff + 1'b1;
            if (step_ff + 1'b1 == count_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_RESP: begin
            rsp_in     = '0;
            rsp_in.inside_res = edge_inside;
            rsp_vld_in = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         step_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         step_ff    <= step_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp.valid      = rsp_vld_ff;
   assign rsp.inside_res = rsp_ff.inside_res;
   assign rsp.status     = rsp_ff.status;

   // table never overflows
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count overflow");
   // a query only runs on a non-empty table
   a_spin_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPIN |-> count_ff != '0)
      else $error("query on empty table");
   // edge unit has drained before the result is formed
   a_resp_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP |-> !edge_busy)
      else $error("edge unit busy at result");
   // no new item while a query is in flight
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept)
      else $error("item accepted while busy");
endmodule

// ===== rtl/core/pipqt_cell.sv =====
// ----------------------------------------------------------------------------
// pipqt_cell: one vertex cell of the ring
// Holds one vertex; during a query it shifts its vertex to the left neighbor
// each cycle so the edge unit sees the ring in order.
// ----------------------------------------------------------------------------
module pipqt_cell #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          load_en,   // append writes this cell
   input  logic                          shift_en,  // rotate the ring
   input  logic signed [COORD_WIDTH-1:0] load_x,
   input  logic signed [COORD_WIDTH-1:0] load_y,
   input  logic signed [COORD_WIDTH-1:0] nbr_x,     // from right neighbor
   input  logic signed [COORD_WIDTH-1:0] nbr_y,
   output logic signed [COORD_WIDTH-1:0] vx,
   output logic signed [COORD_WIDTH-1:0] vy
);
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff, x_in, y_in;

   // pick append data, neighbor data or hold
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (load_en) begin
         x_in = load_x;
         y_in = load_y;
      end else if (shift_en) begin
         x_in = nbr_x;
         y_in = nbr_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign vx = x_ff;
   assign vy = y_ff;
endmodule

// ===== rtl/core/pipqt_edge.sv =====
// ----------------------------------------------------------------------------
// pipqt_edge: edge evaluation unit
// Two-stage pipe: stage one forms differences and the two products of the
// cross term, stage two subtracts them and updates the winding count.
// ----------------------------------------------------------------------------
module pipqt_edge #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,     // clear count and crossing flag
   input  logic                          edge_vld,  // one edge this cycle
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic signed [COORD_WIDTH-1:0] ox,
   input  logic signed [COORD_WIDTH-1:0] oy,
   input  logic signed [COORD_WIDTH-1:0] cx,
   input  logic signed [COORD_WIDTH-1:0] cy,
   output logic                          busy,      // an edge is still in stage two
   output logic                          in_poly
);
   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic [1:0] oq, cq, step;
   logic signed [DW-1:0] dpx, dcy, dcx, dpy;

   logic                 s2_vld_ff;
   logic [1:0]           s2_step_ff;
   logic                 s2_flat_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [PW:0]   s_diff;

   logic signed [pipqt_pkg::ALPHA_WIDTH-1:0] alpha_ff, alpha_in;
   logic                                     hit_ff, hit_in;

   // classify both ends and form differences
   always_comb begin
      oq   = pipqt_pkg::quadrant(ox > px, oy > py);
      cq   = pipqt_pkg::quadrant(cx > px, cy > py);
      step = cq - oq;
      dpx  = DW'(px) - DW'(ox);
      dcy  = DW'(cy) - DW'(oy);
      dcx  = DW'(cx) - DW'(ox);
      dpy  = DW'(py) - DW'(oy);
   end

   // register products of the cross term
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= edge_vld;
      end
      s2_step_ff <= step;
      s2_flat_ff <= (cy == oy);
      p1_ff      <= dpx * dcy;
      p2_ff      <= dcx * dpy;
   end

   assign s_diff = (PW+1)'(p1_ff) - (PW+1)'(p2_ff);

   // accumulate winding count; a crossing on the point latches outside
   always_comb begin
      alpha_in = alpha_ff;
      hit_in   = hit_ff;
      if (start) begin
         alpha_in = '0;
         hit_in   = 1'b0;
      end else if (s2_vld_ff) begin
         case (s2_step_ff)
            pipqt_pkg::STEP_CCW: alpha_in = alpha_ff + 1'b1;
            pipqt_pkg::STEP_CW:  alpha_in = alpha_ff - 1'b1;
            pipqt_pkg::STEP_DIAG: begin
               if (!s2_flat_ff) begin
                  if (s_diff == '0) hit_in = 1'b1;
                  else if (s_diff[PW]) alpha_in = alpha_ff + pipqt_pkg::ALPHA_WIDTH'(2);
                  else alpha_in = alpha_ff - pipqt_pkg::ALPHA_WIDTH'(2);
               end
            end
            default: alpha_in = alpha_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         alpha_ff <= alpha_in;
         hit_ff   <= hit_in;
      end
   end

   assign busy    = s2_vld_ff;
   assign in_poly = !hit_ff &&
                    (alpha_ff == pipqt_pkg::ALPHA_WIDTH'(4) ||
                     alpha_ff == -pipqt_pkg::ALPHA_WIDTH'(4));

   // winding count moves by at most two per edge
   a_alpha_step: assert property (@(posedge clock) disable iff (reset)
      !$past(start) |-> (alpha_ff - $past(alpha_ff) <= 2 &&
                         $past(alpha_ff) - alpha_ff <= 2))
      else $error("winding count jumped");
   // a crossing hit stays until the next query starts
   a_hit_sticky: assert property (@(posedge clock) disable iff (reset)
      hit_ff && !start |=> hit_ff)
      else $error("crossing flag dropped");
   // no edge enters while a query is being started
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !edge_vld)
      else $error("edge during start");
endmodule
